>>> hw/rtl/blb_pkg.sv
// Shared types and constants for the Bernsen local binarizer.
// Used by every module in hw/rtl; depends on nothing else.
package blb_pkg;

    localparam int PIX_W = 8;
    localparam logic [PIX_W-1:0] LEVEL_TOP = 8'hFF;
    localparam logic [PIX_W-1:0] LEVEL_LOW = 8'h00;

    // Configuration field widths and reset values.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int WINDOW_W   = 4;
    localparam int THR_W      = 9;
    localparam int RST_IMAGE_WIDTH  = 640;
    localparam int RST_IMAGE_HEIGHT = 480;
    localparam logic [THR_W-1:0] RST_CONTRAST_LIMIT   = 9'd15;
    localparam logic [THR_W-1:0] RST_GLOBAL_THRESHOLD = 9'd128;

    // Parameter defaults.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_WINDOW = 15;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Depth of the queue between the window front and the threshold back.
    localparam int QDEPTH = 4;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH      = 3'd0,
        CFG_IMAGE_HEIGHT     = 3'd1,
        CFG_WINDOW_SIZE      = 3'd2,
        CFG_CONTRAST_LIMIT   = 3'd3,
        CFG_GLOBAL_THRESHOLD = 3'd4
    } t_cfg_idx;

    // One window result handed from the front to the back.
    typedef struct packed {
        logic [PIX_W-1:0] center;
        logic [PIX_W-1:0] win_min;
        logic [PIX_W-1:0] win_max;
        logic             last;
    } t_win_rec;

    typedef struct packed {
        logic [THR_W-1:0] contrast_limit;
        logic [THR_W-1:0] global_threshold;
    } t_thr_cfg;

endpackage

>>> hw/rtl/bernsen_local_binarizer.sv
// Bernsen local binarizer, top level: configuration registers, front,
// result queue and back. Depends on blb_pkg, blb_front, blb_queue, blb_back.
//
// Usage: pixels of the extended raster grid enter through push/full, one per
// cycle while full is low; each row carries image_width pixels and then
// (window-1)/2 drain items, and the image rows are followed by (window-1)/2
// drain rows. A padding item at an image position is dropped. Binarized
// pixels leave through empty/pop, oldest first; last_of_frame marks the
// final pixel of the image.
// Throughput is one item per cycle while full is low. The column store is
// read at the accepting edge; the vertical min/max, the horizontal min/max
// into the queue and the threshold are then registered in that order. When
// the receiver stalls, results collect in a four-entry queue and full rises
// once the queue and the in-flight stages would overrun it. Reset restores
// the register defaults and restarts the frame at row 0, column 0; the
// column line store is not cleared, since an entry is used only once the
// current frame has written it. Registers must be written by the user only
// while idle; the block itself does not enforce this.
module bernsen_local_binarizer #(
    parameter int MAX_WIDTH  = blb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = blb_pkg::DEF_MAX_WINDOW,
    parameter int MAX_HEIGHT = blb_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [blb_pkg::PIX_W-1:0]       i_pixel,
    input  logic                            i_is_padding,
    output logic                            empty,
    input  logic                            pop,
    output logic [blb_pkg::PIX_W-1:0]       o_out_level,
    output logic                            o_last_of_frame,
    input  logic                            i_cfg_we,
    input  logic [blb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [blb_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import blb_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH + MAX_WINDOW);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + MAX_WINDOW);
    localparam int HALF_W = $clog2(MAX_WINDOW);
    localparam int RST_W  = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
    localparam int RST_H  = (RST_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_IMAGE_HEIGHT;

    logic [COL_W-1:0]  r_img_w, n_img_w, r_ncols, n_ncols;
    logic [ROW_W-1:0]  r_img_h, n_img_h, r_nrows, n_nrows;
    logic [HALF_W-1:0] r_half, n_half;
    t_thr_cfg          r_thr, n_thr;

    logic [WIDTH_W-1:0]  wcfg;
    logic [HEIGHT_W-1:0] hcfg;
    logic [WINDOW_W-1:0] kcfg;
    int                  win;

    logic              take, out_take, rec_valid, rec_pop, q_empty, out_valid;
    logic [1:0]        inflight;
    logic [QCNT_W-1:0] q_count;
    t_win_rec          front_rec, q_rec;

    // Registers are kept in clamped form, with the grid extents derived.
    always_comb begin
        wcfg    = i_cfg_wdata[WIDTH_W-1:0];
        hcfg    = i_cfg_wdata[HEIGHT_W-1:0];
        kcfg    = i_cfg_wdata[WINDOW_W-1:0];
        win     = int'(kcfg);
        n_img_w = r_img_w;
        n_img_h = r_img_h;
        n_half  = r_half;
        n_thr   = r_thr;
        if (win > MAX_WINDOW) begin
            win = MAX_WINDOW;
        end
        if (win < 3) begin
            win = 3;
        end
        if ((win % 2) == 0) begin
            win = win - 1;
        end
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    if (wcfg == '0) begin
                        n_img_w = COL_W'(1);
                    end else if (int'(wcfg) > MAX_WIDTH) begin
                        n_img_w = COL_W'(MAX_WIDTH);
                    end else begin
                        n_img_w = COL_W'(wcfg);
                    end
                end
                CFG_IMAGE_HEIGHT: begin
                    if (hcfg == '0) begin
                        n_img_h = ROW_W'(1);
                    end else if (int'(hcfg) > MAX_HEIGHT) begin
                        n_img_h = ROW_W'(MAX_HEIGHT);
                    end else begin
                        n_img_h = ROW_W'(hcfg);
                    end
                end
                CFG_WINDOW_SIZE:      n_half = HALF_W'((win - 1) / 2);
                CFG_CONTRAST_LIMIT:   n_thr.contrast_limit = i_cfg_wdata[THR_W-1:0];
                CFG_GLOBAL_THRESHOLD: n_thr.global_threshold = i_cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
        n_ncols = n_img_w + COL_W'(n_half);
        n_nrows = n_img_h + ROW_W'(n_half);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= COL_W'(RST_W);
            r_img_h <= ROW_W'(RST_H);
            r_half  <= HALF_W'(1);
            r_ncols <= COL_W'(RST_W + 1);
            r_nrows <= ROW_W'(RST_H + 1);
            r_thr.contrast_limit   <= RST_CONTRAST_LIMIT;
            r_thr.global_threshold <= RST_GLOBAL_THRESHOLD;
        end else begin
            r_img_w <= n_img_w;
            r_img_h <= n_img_h;
            r_half  <= n_half;
            r_ncols <= n_ncols;
            r_nrows <= n_nrows;
            r_thr   <= n_thr;
        end
    end

    // Room is reserved for every item still in the front stages.
    assign full     = ({1'b0, q_count} + (QCNT_W + 1)'(inflight)) >= (QCNT_W + 1)'(QDEPTH);
    assign take     = push && !full;
    assign out_take = pop && out_valid;
    assign empty    = !out_valid;

    blb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W),
        .HALF_W     (HALF_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_pixel      (i_pixel),
        .i_is_padding (i_is_padding),
        .i_img_w      (r_img_w),
        .i_img_h      (r_img_h),
        .i_half       (r_half),
        .i_ncols      (r_ncols),
        .i_nrows      (r_nrows),
        .o_rec_valid  (rec_valid),
        .o_rec        (front_rec),
        .o_inflight   (inflight)
    );

    blb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_valid),
        .i_data  (front_rec),
        .i_pop   (rec_pop),
        .o_data  (q_rec),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    blb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (!q_empty),
        .i_rec       (q_rec),
        .i_thr       (r_thr),
        .i_out_take  (out_take),
        .o_rec_pop   (rec_pop),
        .o_out_valid (out_valid),
        .o_level     (o_out_level),
        .o_last      (o_last_of_frame)
    );

endmodule

>>> hw/rtl/blb_front.sv
// Window front: raster position tracking, column line store, vertical and
// horizontal min/max. Depends on blb_pkg.
module blb_front #(
    parameter int MAX_WIDTH  = blb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = blb_pkg::DEF_MAX_WINDOW,
    parameter int MAX_HEIGHT = blb_pkg::DEF_MAX_HEIGHT,
    parameter int COL_W  = $clog2(MAX_WIDTH + MAX_WINDOW),
    parameter int ROW_W  = $clog2(MAX_HEIGHT + MAX_WINDOW),
    parameter int HALF_W = $clog2(MAX_WINDOW)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic [blb_pkg::PIX_W-1:0]  i_pixel,
    input  logic                       i_is_padding,
    input  logic [COL_W-1:0]           i_img_w,
    input  logic [ROW_W-1:0]           i_img_h,
    input  logic [HALF_W-1:0]          i_half,
    input  logic [COL_W-1:0]           i_ncols,
    input  logic [ROW_W-1:0]           i_nrows,
    output logic                       o_rec_valid,
    output blb_pkg::t_win_rec          o_rec,
    output logic [1:0]                 o_inflight
);
    import blb_pkg::*;

    localparam int SD = MAX_WINDOW - 1;
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int VL = $clog2(SD + 1);
    localparam int VN = 1 << VL;
    localparam int HL = $clog2(MAX_WINDOW);
    localparam int HN = 1 << HL;

    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;

    logic [SD-1:0][PIX_W-1:0] mem [0:MAX_WIDTH-1];
    logic [SD-1:0][PIX_W-1:0] r_rdata;

    logic             r_a_valid;
    logic [ROW_W-1:0] r_a_r;
    logic [COL_W-1:0] r_a_c;
    logic             r_a_inside;
    logic             r_a_incol;
    logic             r_a_colzero;
    logic             r_a_emit;
    logic             r_a_last;
    logic [PIX_W-1:0] r_a_pix;

    logic [PIX_W-1:0] r_wmin [0:MAX_WINDOW-1];
    logic [PIX_W-1:0] r_wmax [0:MAX_WINDOW-1];
    logic [PIX_W-1:0] r_cline [0:MAX_WINDOW-1];
    logic             r_b_valid;
    logic             r_b_last;

    logic             wrap, in_img, skip, adv, col_last, row_last;
    logic [ROW_W-1:0] cur_r;
    logic [COL_W-1:0] cur_c;

    logic [PIX_W-1:0] vmin_t [0:VL][0:VN-1];
    logic [PIX_W-1:0] vmax_t [0:VL][0:VN-1];
    logic [PIX_W-1:0] cmin, cmax, cent_a, top_byte;
    logic [SD-1:0][PIX_W-1:0] new_stack;

    logic [PIX_W-1:0] hmin_t [0:HL][0:HN-1];
    logic [PIX_W-1:0] hmax_t [0:HL][0:HN-1];

    // Position in the extended grid; a grid that shrank under the
    // current position restarts the frame.
    always_comb begin
        wrap     = (r_row >= i_nrows) || (r_col >= i_ncols);
        cur_r    = wrap ? '0 : r_row;
        cur_c    = wrap ? '0 : r_col;
        in_img   = (cur_r < i_img_h) && (cur_c < i_img_w);
        skip     = in_img && i_is_padding;
        adv      = i_take && !skip;
        col_last = ({1'b0, cur_c} + 1'b1) >= {1'b0, i_ncols};
        row_last = ({1'b0, cur_r} + 1'b1) >= {1'b0, i_nrows};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= adv;
            if (i_take) begin
                if (skip) begin
                    r_row <= cur_r;
                    r_col <= cur_c;
                end else if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : cur_r + 1'b1;
                end else begin
                    r_row <= cur_r;
                    r_col <= cur_c + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_r       <= cur_r;
            r_a_c       <= cur_c;
            r_a_inside  <= in_img;
            r_a_incol   <= cur_c < i_img_w;
            r_a_colzero <= cur_c == '0;
            r_a_emit    <= (cur_r >= ROW_W'(i_half)) && (cur_c >= COL_W'(i_half));
            r_a_last    <= row_last && col_last;
            r_a_pix     <= i_pixel;
        end
    end

    // Column stack: read when the item is accepted, written back in the next
    // cycle. The same column comes back at least two items later.
    always_ff @(posedge i_clk) begin
        if (adv && (cur_c < i_img_w)) begin
            r_rdata <= mem[cur_c[AW-1:0]];
        end
        if (r_a_valid && r_a_incol) begin
            mem[r_a_c[AW-1:0]] <= new_stack;
        end
    end

    always_comb begin
        for (int l = 0; l <= VL; l++) begin
            for (int i = 0; i < VN; i++) begin
                vmin_t[l][i] = LEVEL_TOP;
                vmax_t[l][i] = LEVEL_LOW;
            end
        end
        for (int k = 0; k < SD; k++) begin
            if (r_a_incol && ((HALF_W + 1)'(k) < {i_half, 1'b0})
                    && ({1'b0, r_a_r} >= (ROW_W + 1)'(k + 1))
                    && ({1'b0, r_a_r} < ({1'b0, i_img_h} + (ROW_W + 1)'(k + 1)))) begin
                vmin_t[0][k] = r_rdata[k];
                vmax_t[0][k] = r_rdata[k];
            end
        end
        if (r_a_inside) begin
            vmin_t[0][SD] = r_a_pix;
            vmax_t[0][SD] = r_a_pix;
        end
        for (int l = 1; l <= VL; l++) begin
            for (int i = 0; i < (VN >> l); i++) begin
                vmin_t[l][i] = (vmin_t[l-1][2*i] < vmin_t[l-1][2*i+1]) ?
                               vmin_t[l-1][2*i] : vmin_t[l-1][2*i+1];
                vmax_t[l][i] = (vmax_t[l-1][2*i] > vmax_t[l-1][2*i+1]) ?
                               vmax_t[l-1][2*i] : vmax_t[l-1][2*i+1];
            end
        end
        cmin      = vmin_t[VL][0];
        cmax      = vmax_t[VL][0];
        // Entry half-1 of the old stack is the pixel half rows up.
        cent_a    = r_rdata[i_half - 1'b1];
        top_byte  = r_a_inside ? r_a_pix : LEVEL_LOW;
        new_stack = {r_rdata[SD-2:0], top_byte};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            for (int i = 0; i < MAX_WINDOW; i++) begin
                r_wmin[i] <= LEVEL_TOP;
                r_wmax[i] <= LEVEL_LOW;
            end
        end else begin
            r_b_valid <= r_a_valid && r_a_emit;
            if (r_a_valid) begin
                r_wmin[0] <= cmin;
                r_wmax[0] <= cmax;
                for (int i = 1; i < MAX_WINDOW; i++) begin
                    r_wmin[i] <= r_a_colzero ? LEVEL_TOP : r_wmin[i-1];
                    r_wmax[i] <= r_a_colzero ? LEVEL_LOW : r_wmax[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_b_last   <= r_a_last;
            r_cline[0] <= cent_a;
            for (int i = 1; i < MAX_WINDOW; i++) begin
                r_cline[i] <= r_cline[i-1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l <= HL; l++) begin
            for (int i = 0; i < HN; i++) begin
                hmin_t[l][i] = LEVEL_TOP;
                hmax_t[l][i] = LEVEL_LOW;
            end
        end
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if ((HALF_W + 1)'(i) <= {i_half, 1'b0}) begin
                hmin_t[0][i] = r_wmin[i];
                hmax_t[0][i] = r_wmax[i];
            end
        end
        for (int l = 1; l <= HL; l++) begin
            for (int i = 0; i < (HN >> l); i++) begin
                hmin_t[l][i] = (hmin_t[l-1][2*i] < hmin_t[l-1][2*i+1]) ?
                               hmin_t[l-1][2*i] : hmin_t[l-1][2*i+1];
                hmax_t[l][i] = (hmax_t[l-1][2*i] > hmax_t[l-1][2*i+1]) ?
                               hmax_t[l-1][2*i] : hmax_t[l-1][2*i+1];
            end
        end
    end

    assign o_rec_valid     = r_b_valid;
    assign o_rec.center    = r_cline[i_half];
    assign o_rec.win_min   = hmin_t[HL][0];
    assign o_rec.win_max   = hmax_t[HL][0];
    assign o_rec.last      = r_b_last;
    assign o_inflight      = {1'b0, r_a_valid} + {1'b0, r_b_valid};

endmodule

>>> hw/rtl/blb_queue.sv
// Short queue of window results between the front and the back.
// Depends on blb_pkg.
module blb_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  blb_pkg::t_win_rec            i_data,
    input  logic                         i_pop,
    output blb_pkg::t_win_rec            o_data,
    output logic                         o_empty,
    output logic [blb_pkg::QCNT_W-1:0]   o_count
);
    import blb_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    t_win_rec          r_mem [0:QDEPTH-1];
    logic [PW-1:0]     r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_empty = r_count == '0;
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> ((r_count < QCNT_W'(QDEPTH)) || i_pop))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue underflow");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count mismatch");

endmodule

>>> hw/rtl/blb_back.sv
// Threshold back end: local or global threshold, comparison and the output
// register. Depends on blb_pkg.
module blb_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rec_valid,
    input  blb_pkg::t_win_rec          i_rec,
    input  blb_pkg::t_thr_cfg          i_thr,
    input  logic                       i_out_take,
    output logic                       o_rec_pop,
    output logic                       o_out_valid,
    output logic [blb_pkg::PIX_W-1:0]  o_level,
    output logic                       o_last
);
    import blb_pkg::*;

    logic             r_valid;
    logic [PIX_W-1:0] r_level;
    logic             r_last;

    logic                    load;
    logic [PIX_W:0]          sum;
    logic signed [PIX_W+1:0] spread;
    logic [THR_W-1:0]        thr;

    always_comb begin
        load   = i_rec_valid && (!r_valid || i_out_take);
        sum    = {1'b0, i_rec.win_max} + {1'b0, i_rec.win_min};
        spread = $signed({2'b00, i_rec.win_max}) - $signed({2'b00, i_rec.win_min});
        if (spread < $signed({1'b0, i_thr.contrast_limit})) begin
            thr = i_thr.global_threshold;
        end else begin
            thr = {1'b0, sum[PIX_W:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_out_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_level <= ({1'b0, i_rec.center} < thr) ? LEVEL_LOW : LEVEL_TOP;
            r_last  <= i_rec.last;
        end
    end

    assign o_rec_pop   = load;
    assign o_out_valid = r_valid;
    assign o_level     = r_level;
    assign o_last      = r_last;

endmodule

>>> tb/tb.sv
// Self-checking testbench for bernsen_local_binarizer: streams whole frames
// over the push/full port and checks every popped pixel against an in-bench
// window predictor. Depends on blb_pkg and the bernsen_local_binarizer RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import blb_pkg::*;

    localparam int MAXW  = DEF_MAX_WIDTH;
    localparam int MAXWN = DEF_MAX_WINDOW;
    localparam int MAXH  = DEF_MAX_HEIGHT;
    localparam int DEPTH = MAXWN - 1;

    typedef struct packed {
        logic [PIX_W-1:0] level;
        logic             last;
    } t_bin_pix;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [PIX_W-1:0]      i_pixel = '0;
    logic                  i_is_padding = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [PIX_W-1:0]      o_out_level;
    logic                  o_last_of_frame;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    bernsen_local_binarizer dut (.*);

    always #6 i_clk = ~i_clk;

    // Predictor state: configuration, per-column row history and column extrema.
    logic [WIDTH_W-1:0]  img_w;
    logic [HEIGHT_W-1:0] img_h;
    logic [WINDOW_W-1:0] win_sz;
    logic [THR_W-1:0]    contrast_lim;
    logic [THR_W-1:0]    global_thr;
    logic [PIX_W-1:0]    row_hist [MAXW][DEPTH];
    logic [PIX_W-1:0]    col_min [MAXWN];
    logic [PIX_W-1:0]    col_max [MAXWN];
    int unsigned         grid_row, grid_col;

    t_bin_pix            binarized_q[$];
    int                  err_count = 0;
    bit                  idle_en = 1'b1;
    int                  hold_cycles = 0;
    int                  random_items = 0;

    function automatic int unsigned eff_width();
        if (img_w < 1) return 1;
        if (img_w > MAXW) return MAXW;
        return img_w;
    endfunction

    function automatic int unsigned eff_height();
        if (img_h < 1) return 1;
        if (img_h > MAXH) return MAXH;
        return img_h;
    endfunction

    function automatic int unsigned half_win();
        int unsigned w;
        w = win_sz;
        if (w > MAXWN) w = MAXWN;
        if (w < 3) w = 3;
        if (w % 2 == 0) w = w - 1;
        return (w - 1) / 2;
    endfunction

    function automatic void clear_columns();
        for (int i = 0; i < MAXWN; i++) begin
            col_min[i] = LEVEL_TOP;
            col_max[i] = LEVEL_LOW;
        end
    endfunction

    // Advances the grid by one accepted item and queues the pixel it completes.
    function automatic void predict_binarized(input logic [PIX_W-1:0] pix, input logic pad);
        int unsigned wd, ht, hw, nc, nr, r, c;
        int cmin, cmax, hmin, hmax, thr, ctr;
        logic ins;
        t_bin_pix e;
        wd = eff_width();
        ht = eff_height();
        hw = half_win();
        nc = wd + hw;
        nr = ht + hw;
        if (grid_row >= nr || grid_col >= nc) begin
            grid_row = 0;
            grid_col = 0;
        end
        r = grid_row;
        c = grid_col;
        ins = (r < ht) && (c < wd);
        if (ins && pad) return;
        if (c == 0) clear_columns();
        cmin = LEVEL_TOP;
        cmax = LEVEL_LOW;
        if (c < wd) begin
            for (int k = 0; k < 2 * hw; k++) begin
                if (r >= k + 1 && r - 1 - k < ht) begin
                    if (row_hist[c][k] < cmin) cmin = row_hist[c][k];
                    if (row_hist[c][k] > cmax) cmax = row_hist[c][k];
                end
            end
            if (ins) begin
                if (pix < cmin) cmin = pix;
                if (pix > cmax) cmax = pix;
            end
            for (int k = DEPTH - 1; k >= 1; k--) row_hist[c][k] = row_hist[c][k-1];
            row_hist[c][0] = ins ? pix : LEVEL_LOW;
        end
        for (int i = MAXWN - 1; i >= 1; i--) begin
            col_min[i] = col_min[i-1];
            col_max[i] = col_max[i-1];
        end
        col_min[0] = PIX_W'(cmin);
        col_max[0] = PIX_W'(cmax);
        if (c + 1 >= nc) begin
            grid_col = 0;
            grid_row = (r + 1 >= nr) ? 0 : r + 1;
        end else begin
            grid_col = c + 1;
        end
        if (r < hw || c < hw) return;
        hmin = LEVEL_TOP;
        hmax = LEVEL_LOW;
        for (int i = 0; i <= 2 * hw; i++) begin
            if (col_min[i] < hmin) hmin = col_min[i];
            if (col_max[i] > hmax) hmax = col_max[i];
        end
        ctr = row_hist[c-hw][hw];
        thr = (hmax + hmin) / 2;
        if (hmax - hmin < int'(contrast_lim)) thr = global_thr;
        e.level = (ctr < thr) ? LEVEL_LOW : LEVEL_TOP;
        e.last = (r == nr - 1) && (c == nc - 1);
        binarized_q.push_back(e);
    endfunction

    task automatic report(input string what, input int got, input int want);
        err_count++;
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Sends one item; push stays high when the next item follows at once.
    task automatic send_item(input logic [PIX_W-1:0] pix, input logic pad);
        int gap;
        push <= 1'b1;
        i_pixel <= pix;
        i_is_padding <= pad;
        do @(posedge i_clk); while (full);
        predict_binarized(pix, pad);
        gap = idle_en ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        wait (binarized_q.size() == 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_regs(input int w, input int h, input int win, input int cl,
                              input int gt);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_wdata <= CFG_DATA_W'(w);
        @(posedge i_clk);
        img_w = WIDTH_W'(w);
        i_cfg_index <= CFG_IMAGE_HEIGHT;
        i_cfg_wdata <= CFG_DATA_W'(h);
        @(posedge i_clk);
        img_h = HEIGHT_W'(h);
        i_cfg_index <= CFG_WINDOW_SIZE;
        i_cfg_wdata <= CFG_DATA_W'(win);
        @(posedge i_clk);
        win_sz = WINDOW_W'(win);
        i_cfg_index <= CFG_CONTRAST_LIMIT;
        i_cfg_wdata <= CFG_DATA_W'(cl);
        @(posedge i_clk);
        contrast_lim = THR_W'(cl);
        i_cfg_index <= CFG_GLOBAL_THRESHOLD;
        i_cfg_wdata <= CFG_DATA_W'(gt);
        @(posedge i_clk);
        global_thr = THR_W'(gt);
        i_cfg_we <= 1'b0;
    endtask

    // One whole frame; spread 255 gives full-range pixels, 0 flat ones, others a band.
    task automatic send_frame(input int spread, input int pad_odds);
        int unsigned wd, ht, hw, base;
        int v;
        wd = eff_width();
        ht = eff_height();
        hw = half_win();
        base = $urandom_range(0, 255);
        for (int r = 0; r < ht + hw; r++) begin
            for (int c = 0; c < wd + hw; c++) begin
                if (r < ht && c < wd) begin
                    if (pad_odds > 0 && $urandom_range(0, pad_odds) == 0)
                        send_item(PIX_W'($urandom_range(0, 255)), 1'b1);
                    if (spread >= 255) v = $urandom_range(0, 255);
                    else v = base + $urandom_range(0, spread) - spread / 2;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                    send_item(PIX_W'(v), 1'b0);
                end else begin
                    send_item(PIX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    // Receiver: random stalls per transfer, plus a long hold-off on request.
    initial begin
        int stall;
        t_bin_pix e;
        forever begin
            stall = idle_en ? $urandom_range(0, 7) : 0;
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty || !i_rst_n);
            if (binarized_q.size() == 0) begin
                report("unexpected transfer, level", o_out_level, -1);
            end else begin
                e = binarized_q.pop_front();
                if (o_out_level !== e.level) report("out_level", o_out_level, e.level);
                if (o_last_of_frame !== e.last)
                    report("last_of_frame", o_last_of_frame, e.last);
            end
        end
    end

    task automatic test_directed();
        logic [PIX_W-1:0] pix;
        // 3x3 image, window 3: extreme pixels, padding inside the image and
        // plain pixels at drain positions.
        write_regs(3, 3, 3, 15, 128);
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                pix = ((r + c) % 2) ? LEVEL_TOP : LEVEL_LOW;
                if (r < 3 && c < 3) begin
                    if (c == 1) send_item(8'hA5, 1'b1);
                    send_item(pix, 1'b0);
                end else begin
                    send_item(8'h5A, 1'b0);
                end
            end
        end
        // Flat field falls back to the global threshold.
        write_regs(3, 3, 3, 256, 256);
        send_frame(0, 0);
    endtask

    task automatic test_clamping();
        write_regs(0, 4, 4, 0, 0);       // width clamps to 1, even window drops to 3
        send_frame(255, 4);
        write_regs(5, 0, 0, 40, 100);    // height clamps to 1, window rises to 3
        send_frame(255, 4);
        // Width clamps to the maximum; only the start of the first row is sent,
        // and the next frame's smaller grid restarts the position.
        write_regs(2047, 1, 14, 20, 90);
        for (int i = 0; i < 60; i++) send_item(PIX_W'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_extremes();
        // Widest row: only its start is sent before the grid shrinks again.
        write_regs(1024, 3, 3, 0, 0);
        for (int i = 0; i < 60; i++) send_item(PIX_W'($urandom_range(0, 255)), 1'b0);
        // Widest window, clipped on every side of a small image.
        write_regs(3, 3, 15, 0, 0);
        send_frame(255, 0);
        // Tallest image: twenty rows are sent, so the next smaller grid restarts.
        idle_en = 1'b0;
        write_regs(3, 4096, 3, 256, 0);
        for (int i = 0; i < 80; i++) send_item(PIX_W'($urandom_range(0, 255)), 1'b0);
        idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        write_regs(12, 8, 5, 30, 128);
        hold_cycles = 300;
        send_frame(255, 0);
        // Sender pauses mid-frame until the block has emptied.
        write_regs(10, 6, 7, 10, 60);
        for (int i = 0; i < 50; i++) send_item(PIX_W'($urandom_range(0, 255)), 1'b0);
        push <= 1'b0;
        wait (binarized_q.size() == 0);
        for (int i = 0; i < 67; i++) send_item(PIX_W'($urandom_range(0, 255)), 1'b0);
        send_frame(255, 0);
    endtask

    task automatic test_random();
        int spreads[4] = '{0, 6, 40, 255};
        while (random_items < 150) begin
            idle_en = ($urandom_range(0, 3) != 0);
            write_regs($urandom_range(3, 16), $urandom_range(3, 10), $urandom_range(3, 15),
                       $urandom_range(0, 256), $urandom_range(0, 256));
            send_frame(spreads[$urandom_range(0, 3)], $urandom_range(0, 1) ? 12 : 0);
            random_items += (eff_width() + half_win()) * (eff_height() + half_win());
        end
        idle_en = 1'b1;
    endtask

    initial begin
        img_w = WIDTH_W'(RST_IMAGE_WIDTH);
        img_h = HEIGHT_W'(RST_IMAGE_HEIGHT);
        win_sz = 3;
        contrast_lim = RST_CONTRAST_LIMIT;
        global_thr = RST_GLOBAL_THRESHOLD;
        grid_row = 0;
        grid_col = 0;
        clear_columns();
        for (int c = 0; c < MAXW; c++)
            for (int k = 0; k < DEPTH; k++) row_hist[c][k] = LEVEL_LOW;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_clamping();
        test_backpressure();
        test_extremes();
        test_random();
        wait_drained();
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
